@@ design/ssa_pkg.sv @@
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared types and constants of the swap slot allocator.
// ----------------------------------------------------------------------------
package ssa_pkg;

  localparam int MAX_SLOTS        = 1024;
  localparam int SECTORS_PER_PAGE = 8;

  localparam int SLOT_W   = 10;
  localparam int FRAME_W  = 20;
  localparam int COUNT_W  = 11;
  localparam int SECTOR_W = 13;
  localparam int MADDR_W  = 32;
  localparam int STAT_W   = 2;

  localparam int WORD_W = 32;
  localparam int ROWS   = (MAX_SLOTS + WORD_W - 1) / WORD_W;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int BIT_W  = $clog2(WORD_W);
  localparam int STEP_W = (SECTORS_PER_PAGE > 1) ? $clog2(SECTORS_PER_PAGE) : 1;

  localparam int PAGE_SHIFT   = 12;
  localparam int SECTOR_SHIFT = 9;

  localparam int PDATA_W = 32;
  localparam int PADDR_W = 3;
  localparam int REG_W   = PADDR_W - 2;

  localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET = COUNT_W'(1024);
  localparam logic [REG_W-1:0]   REG_SLOT_COUNT   = REG_W'(0);

  typedef enum logic {
    OP_PAGE_OUT = 1'b0,
    OP_PAGE_IN  = 1'b1
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_USED = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_EMIT
  } state_t;

endpackage

@@ design/ssa_req_if.sv @@
// ----------------------------------------------------------------------------
// ssa_req_if
// Request channel: page-out and page-in items.
// ----------------------------------------------------------------------------
interface ssa_req_if import ssa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [SLOT_W-1:0]  requested_slot;
  logic [FRAME_W-1:0] frame_number;

  modport source (output valid, op, requested_slot, frame_number, input ready);
  modport sink   (input valid, op, requested_slot, frame_number, output ready);
endinterface

@@ design/ssa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ssa_rsp_if
// Result channel: sector commands and status items.
// ----------------------------------------------------------------------------
interface ssa_rsp_if import ssa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                is_disk_write;
  logic [SLOT_W-1:0]   slot_number;
  logic [SECTOR_W-1:0] sector_address;
  logic [MADDR_W-1:0]  memory_address;
  logic [STAT_W-1:0]   status;
  logic                last;

  modport source (output valid, is_disk_write, slot_number, sector_address,
                  memory_address, status, last, input ready);
  modport sink   (input valid, is_disk_write, slot_number, sector_address,
                  memory_address, status, last, output ready);
endinterface

@@ design/swap_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// swap_slot_allocator
// First-fit swap slot allocator over a used-map memory with sector commands.
// ----------------------------------------------------------------------------
//   channel   dir  handshake        item
//   request   in   valid/ready      op, requested_slot, frame_number
//   result    out  valid/ready      one sector command or one status
//   apb       in   psel/penable     slot_count at byte address 0
//
// One request at a time: accept in an idle cycle, map read and write-back in the
// lookup state, then eight result items (one for a status), set by the sector count.
// Reset clears the row valid bits and the full bits at once; no sweep.
// Request ready stays low while reset is high.
// A stalled result holds its values until taken.
// ----------------------------------------------------------------------------
module swap_slot_allocator import ssa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  ssa_req_if.sink            request,
  ssa_rsp_if.source          result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  state_t state, state_next;

  logic [COUNT_W-1:0] slot_count;
  logic [COUNT_W-1:0] limit;

  logic [WORD_W-1:0] map_mem [ROWS];
  logic [WORD_W-1:0] rdata;
  logic [ROWS-1:0]   row_valid;
  logic [ROWS-1:0]   full_bits;
  logic              rv;

  logic [ROW_W-1:0]  rd_addr;
  logic              mem_we;
  logic [WORD_W-1:0] wdata;

  op_t                op_r;
  logic [SLOT_W-1:0]  req_r;
  logic [FRAME_W-1:0] frame_r;
  logic [ROW_W-1:0]   row_r;
  logic               all_full_r;
  logic               range_r;

  logic [SLOT_W-1:0]  slot_r;
  status_t            status_r;
  logic [STEP_W-1:0]  step_r;

  logic              in_fire;
  logic              out_fire;
  logic              load;
  logic              emit_done;
  logic [WORD_W-1:0] word;
  logic [BIT_W-1:0]  free_bit;
  logic [SLOT_W-1:0] cand_slot;
  logic [BIT_W-1:0]  req_bit;
  status_t           status_next;
  logic [SLOT_W-1:0] slot_next;
  logic              is_last;

  function automatic logic [ROW_W-1:0] first_open_row(input logic [ROWS-1:0] full);
    logic [ROW_W-1:0] idx;
    idx = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (!full[i]) idx = ROW_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [BIT_W-1:0] first_zero_bit(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= SLOT_COUNT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1:2] == REG_SLOT_COUNT) begin
      slot_count <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_SLOT_COUNT) prdata = PDATA_W'(slot_count);
  end

  assign limit = (slot_count > COUNT_W'(MAX_SLOTS)) ? COUNT_W'(MAX_SLOTS) : slot_count;

  // control
  assign in_fire  = request.valid && request.ready;
  assign out_fire = result.valid && result.ready;
  assign is_last  = (status_r != ST_OK) || (step_r == STEP_W'(SECTORS_PER_PAGE - 1));

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next    = state;
    request.ready = 1'b0;
    result.valid  = 1'b0;
    load          = 1'b0;
    emit_done     = 1'b0;
    unique case (state)
      S_IDLE: begin
        request.ready = !rst;
        if (request.valid) state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        load       = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        result.valid = 1'b1;
        if (result.ready && is_last) begin
          emit_done  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // map read address
  assign rd_addr = (request.op == OP_PAGE_OUT) ? first_open_row(full_bits)
                                                : request.requested_slot[SLOT_W-1:BIT_W];

  always_ff @(posedge clk) begin
    rdata <= map_mem[rd_addr];
    rv    <= row_valid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r       <= op_t'(request.op);
      req_r      <= request.requested_slot;
      frame_r    <= request.frame_number;
      row_r      <= rd_addr;
      all_full_r <= &full_bits;
      range_r    <= COUNT_W'(request.requested_slot) >= limit;
    end
  end

  // lookup and modify
  assign word      = rv ? rdata : '0;
  assign free_bit  = first_zero_bit(word);
  assign cand_slot = SLOT_W'({row_r, free_bit});
  assign req_bit   = req_r[BIT_W-1:0];

  always_comb begin
    mem_we      = 1'b0;
    wdata       = word;
    status_next = ST_OK;
    slot_next   = '0;
    if (op_r == OP_PAGE_OUT) begin
      if (all_full_r || COUNT_W'(cand_slot) >= limit) begin
        status_next = ST_FULL;
      end else begin
        slot_next         = cand_slot;
        wdata[free_bit]   = 1'b1;
        mem_we            = load;
      end
    end else begin
      if (range_r) begin
        status_next = ST_RANGE;
      end else if (!word[req_bit]) begin
        status_next = ST_NOT_USED;
      end else begin
        slot_next       = req_r;
        wdata[req_bit]  = 1'b0;
        mem_we          = load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) map_mem[row_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      full_bits <= '0;
    end else if (mem_we) begin
      row_valid[row_r] <= 1'b1;
      full_bits[row_r] <= &wdata;
    end
  end

  // result
  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= status_next;
      slot_r   <= slot_next;
      step_r   <= '0;
    end else if (out_fire && !emit_done) begin
      step_r <= step_r + STEP_W'(1);
    end
  end

  assign result.is_disk_write = (op_r == OP_PAGE_OUT);
  assign result.status        = status_r;
  assign result.last          = is_last;
  assign result.slot_number   = slot_r;
  assign result.sector_address = (status_r == ST_OK) ?
      SECTOR_W'(slot_r * SECTORS_PER_PAGE + step_r) : '0;
  assign result.memory_address = (status_r == ST_OK) ?
      (MADDR_W'(frame_r) << PAGE_SHIFT) + (MADDR_W'(step_r) << SECTOR_SHIFT) : '0;

  // checks
  a_status_single: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status != ST_OK |-> result.last)
    else $error("status item without last");

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status == ST_OK |-> COUNT_W'(result.slot_number) < limit)
    else $error("slot at or above slot count");

  a_full_track: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> full_bits[$past(row_r)] == (&$past(wdata)))
    else $error("full bit out of step with map row");

endmodule
